// File: sv/sit_pkg.sv
package sit_pkg;

  // Request kinds on req_type_i.
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_READ   = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_READ     = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  localparam int unsigned OUT_VALUE_WIDTH = 32;
  localparam int unsigned FILL_WIDTH      = 5;

  // Control broadcast from the sequencer to every cell of the row.
  typedef struct packed {
    logic insert;
    logic rotate;
  } cell_ctl_t;

endpackage

// File: sv/sorted_insert_table.sv
// Sorted insert table: keeps up to CAPACITY signed values in ascending order.
// Requests enter on start_i with req_type_i and value_i; a request is taken at a
// rising edge where start_i is high and busy_o is low.
// An insert gives one result in the cycle after it is taken (status inserted, or
// full when the table already holds CAPACITY entries and the value is dropped).
// Inserts can follow one another every cycle: every cell compares its entry with
// the new value in parallel and either keeps it, takes the new value or takes its
// lower neighbor's entry.
// A read of N stored entries gives N results on consecutive cycles, starting in
// the cycle after the request, lowest value first, with last_o on the final one.
// The row rotates one place per cycle and the head cell drives out_value_o, so
// busy_o is high while those results stream out. A read of an empty table gives
// one result with status empty in the next cycle.
// Each result is on the ports for exactly one cycle while done_o is high; the
// receiver cannot stall the block.
// Reset empties the table at once; stored values are not cleared.
module sorted_insert_table #(
  parameter int unsigned CAPACITY    = 16,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        start_i,
  output logic                                        busy_o,
  input  logic                                        req_type_i,
  input  logic signed [sit_pkg::OUT_VALUE_WIDTH-1:0]  value_i,
  output logic                                        done_o,
  output logic signed [sit_pkg::OUT_VALUE_WIDTH-1:0]  out_value_o,
  output logic        [1:0]                           status_o,
  output logic                                        last_o,
  output logic        [sit_pkg::FILL_WIDTH-1:0]       fill_count_o
);
  import sit_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] rd_left_q, rd_left_d;
  logic          res_valid_q, res_valid_d;
  logic [1:0]    res_status_q, res_status_d;
  logic [FILL_WIDTH-1:0] res_fill_q, res_fill_d;

  logic accept;
  logic is_insert;
  logic is_full;
  logic streaming;
  cell_ctl_t ctl;
  logic signed [VALUE_WIDTH-1:0] ins_val;

  logic signed [VALUE_WIDTH-1:0] cell_val [CAPACITY];
  logic                          cell_lt  [CAPACITY];

  assign streaming = (rd_left_q != '0);
  assign busy_o    = streaming;
  assign accept    = start_i && !busy_o;
  assign is_insert = (req_type_i == REQ_INSERT);
  assign is_full   = (count_q == CW'(CAPACITY));
  assign ins_val   = VALUE_WIDTH'(value_i);

  assign ctl.insert = accept && is_insert && !is_full;
  assign ctl.rotate = streaming;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                          prev_lt;
    logic signed [VALUE_WIDTH-1:0] prev_val;
    logic signed [VALUE_WIDTH-1:0] next_val;

    if (i == 0) begin : g_first
      assign prev_lt  = 1'b1;
      assign prev_val = ins_val;
    end else begin : g_mid
      assign prev_lt  = cell_lt[i-1];
      assign prev_val = cell_val[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_val = cell_val[0];
    end else begin : g_inner
      assign next_val = cell_val[i+1];
    end

    sit_cell #(
      .VALUE_WIDTH(VALUE_WIDTH)
    ) u_cell (
      .clk_i     (clk_i),
      .ctl_i     (ctl),
      .ins_val_i (ins_val),
      .in_use_i  (CW'(i) < count_q),
      .is_tail_i (CW'(i + 1) == count_q),
      .prev_lt_i (prev_lt),
      .prev_val_i(prev_val),
      .next_val_i(next_val),
      .head_val_i(cell_val[0]),
      .lt_o      (cell_lt[i]),
      .val_o     (cell_val[i])
    );
  end

  always_comb begin
    count_d      = count_q;
    rd_left_d    = rd_left_q;
    res_valid_d  = 1'b0;
    res_status_d = res_status_q;
    res_fill_d   = res_fill_q;
    if (streaming) begin
      rd_left_d = rd_left_q - CW'(1);
    end
    if (accept) begin
      if (is_insert) begin
        res_valid_d = 1'b1;
        if (is_full) begin
          res_status_d = ST_FULL;
          res_fill_d   = FILL_WIDTH'(count_q);
        end else begin
          count_d      = count_q + CW'(1);
          res_status_d = ST_INSERTED;
          res_fill_d   = FILL_WIDTH'(count_q + CW'(1));
        end
      end else if (count_q == '0) begin
        res_valid_d  = 1'b1;
        res_status_d = ST_EMPTY;
        res_fill_d   = '0;
      end else begin
        rd_left_d = count_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rd_left_q   <= '0;
      res_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      rd_left_q   <= rd_left_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_status_q <= res_status_d;
    res_fill_q   <= res_fill_d;
  end

  assign done_o       = res_valid_q || streaming;
  assign status_o     = streaming ? ST_READ : res_status_q;
  assign last_o       = streaming ? (rd_left_q == CW'(1)) : 1'b1;
  assign fill_count_o = streaming ? FILL_WIDTH'(count_q) : res_fill_q;
  assign out_value_o  = streaming ? OUT_VALUE_WIDTH'(cell_val[0]) : '0;

endmodule

// File: sv/sit_cell.sv
module sit_cell #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                          clk_i,
  input  sit_pkg::cell_ctl_t            ctl_i,
  input  logic signed [VALUE_WIDTH-1:0] ins_val_i,
  input  logic                          in_use_i,
  input  logic                          is_tail_i,
  input  logic                          prev_lt_i,
  input  logic signed [VALUE_WIDTH-1:0] prev_val_i,
  input  logic signed [VALUE_WIDTH-1:0] next_val_i,
  input  logic signed [VALUE_WIDTH-1:0] head_val_i,
  output logic                          lt_o,
  output logic signed [VALUE_WIDTH-1:0] val_o
);
  import sit_pkg::*;

  logic signed [VALUE_WIDTH-1:0] val_q;
  logic signed [VALUE_WIDTH-1:0] val_d;

  // Stored entries form a sorted prefix, so the less-than flags form a prefix too.
  assign lt_o  = in_use_i && (val_q < ins_val_i);
  assign val_o = val_q;

  always_comb begin
    val_d = val_q;
    if (ctl_i.insert) begin
      if (lt_o) begin
        val_d = val_q;
      end else if (prev_lt_i) begin
        val_d = ins_val_i;
      end else begin
        val_d = prev_val_i;
      end
    end else if (ctl_i.rotate) begin
      // The head entry wraps around to the tail of the occupied prefix during a read.
      val_d = is_tail_i ? head_val_i : next_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

// File: sv/sit_checker.sv
module sit_checker (
  input logic                                       clk_i,
  input logic                                       rst_ni,
  input logic                                       start_i,
  input logic                                       busy_o,
  input logic                                       done_o,
  input logic signed [sit_pkg::OUT_VALUE_WIDTH-1:0] out_value_o,
  input logic        [1:0]                          status_o,
  input logic                                       last_o,
  input logic        [sit_pkg::FILL_WIDTH-1:0]      fill_count_o
);
  import sit_pkg::*;

  // Every request gives its first result in the following cycle.
  a_first_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> done_o)
    else $error("request without a result in the next cycle");

  // The block only reports busy while it streams read results.
  a_busy_streams: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> (done_o && status_o == ST_READ))
    else $error("busy without a read result on the ports");

  // A read stream continues until its last result.
  a_stream_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_READ && !last_o) |=> (done_o && status_o == ST_READ))
    else $error("read stream ended before its last result");

  // Single results are always marked last and carry a zero value.
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_READ) |-> (last_o && out_value_o == '0))
    else $error("non-read result not marked last or value not zero");

  // An empty status only comes from an empty table.
  a_empty_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_EMPTY) |-> (fill_count_o == '0))
    else $error("empty status with a nonzero fill count");

endmodule

bind sorted_insert_table sit_checker u_sit_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .done_o      (done_o),
  .out_value_o (out_value_o),
  .status_o    (status_o),
  .last_o      (last_o),
  .fill_count_o(fill_count_o)
);

// File: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import sit_pkg::*;

  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned CYCLE_LIMIT = 300000;

  typedef logic signed [OUT_VALUE_WIDTH-1:0] word_t;

  localparam word_t VALUE_MIN = 32'sh8000_0000;
  localparam word_t VALUE_MAX = 32'sh7FFF_FFFF;

  typedef struct {
    word_t                 value;
    logic [1:0]            status;
    logic                  last;
    logic [FILL_WIDTH-1:0] fill;
  } table_result_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start_i;
  logic                  busy_o;
  logic                  req_type_i;
  word_t                 value_i;
  logic                  done_o;
  word_t                 out_value_o;
  logic [1:0]            status_o;
  logic                  last_o;
  logic [FILL_WIDTH-1:0] fill_count_o;

  // Sorted copy of what the block should hold, and the results still owed.
  word_t         shadow_values[$];
  table_result_t pending_results[$];

  int unsigned sender_idle_pct;
  int unsigned cycle_count;
  int unsigned mismatch_count;
  int unsigned n_requests;
  int unsigned n_inserted;
  int unsigned n_dropped;
  int unsigned n_reads;
  int unsigned n_checked;

  sorted_insert_table #(
    .CAPACITY   (TABLE_DEPTH),
    .VALUE_WIDTH(OUT_VALUE_WIDTH)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .req_type_i  (req_type_i),
    .value_i     (value_i),
    .done_o      (done_o),
    .out_value_o (out_value_o),
    .status_o    (status_o),
    .last_o      (last_o),
    .fill_count_o(fill_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("Verification failed");
      $finish;
    end
  end

  task automatic count_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
  endtask

  // Updates the shadow table for one accepted request and queues its results.
  task automatic apply_to_shadow_table(input logic req_type, input word_t value);
    table_result_t r;
    int unsigned   pos;
    r.value = '0;
    r.last  = 1'b1;
    n_requests++;
    if (req_type == REQ_INSERT) begin
      if (shadow_values.size() >= TABLE_DEPTH) begin
        r.status = ST_FULL;
        n_dropped++;
      end else begin
        pos = 0;
        while (pos < shadow_values.size() && shadow_values[pos] < value) pos++;
        shadow_values.insert(pos, value);
        r.status = ST_INSERTED;
        n_inserted++;
      end
      r.fill = FILL_WIDTH'(shadow_values.size());
      pending_results.push_back(r);
    end else begin
      n_reads++;
      if (shadow_values.size() == 0) begin
        r.status = ST_EMPTY;
        r.fill   = '0;
        pending_results.push_back(r);
      end else begin
        foreach (shadow_values[i]) begin
          r.value  = shadow_values[i];
          r.status = ST_READ;
          r.last   = (i == shadow_values.size() - 1);
          r.fill   = FILL_WIDTH'(shadow_values.size());
          pending_results.push_back(r);
        end
      end
    end
  endtask

  always @(posedge clk_i) begin : check_results
    table_result_t want;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        count_mismatch($sformatf("unexpected result value=%0d status=%0d last=%0d fill=%0d",
                                 out_value_o, status_o, last_o, fill_count_o));
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (out_value_o !== want.value || status_o !== want.status ||
            last_o !== want.last || fill_count_o !== want.fill) begin
          count_mismatch($sformatf(
            "expected value=%0d status=%0d last=%0d fill=%0d, got value=%0d status=%0d last=%0d fill=%0d",
            want.value, want.status, want.last, want.fill,
            out_value_o, status_o, last_o, fill_count_o));
        end
      end
    end
  end

  // Drives one request, holds it until the block takes it, then predicts it.
  // start_i stays high after acceptance so back-to-back requests need no toggle.
  task automatic send_request(input logic req_type, input word_t value);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct && gap < 40) gap++;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i    <= 1'b1;
    req_type_i <= req_type;
    value_i    <= value;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    apply_to_shadow_table(req_type, value);
  endtask

  task automatic wait_until_drained();
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  function automatic word_t pick_insert_value();
    case ($urandom_range(5))
      0: return $urandom_range(1) ? VALUE_MAX : VALUE_MIN;
      1: begin
        if (shadow_values.size() != 0)
          return shadow_values[$urandom_range(shadow_values.size() - 1)];
        return word_t'($urandom);
      end
      2: return word_t'($urandom_range(16)) - 8;
      default: return word_t'($urandom);
    endcase
  endfunction

  task automatic test_empty_read();
    send_request(REQ_READ, 32'hFFFF_FFFF);
  endtask

  // Both ends of the range, zero and its neighbors, and repeats of equal values.
  task automatic test_extreme_values();
    send_request(REQ_INSERT, VALUE_MAX);
    send_request(REQ_INSERT, VALUE_MIN);
    send_request(REQ_INSERT, 32'sd0);
    send_request(REQ_READ, 32'h0);
    send_request(REQ_INSERT, -32'sd1);
    send_request(REQ_INSERT, 32'sd1);
    send_request(REQ_INSERT, 32'sd0);
    send_request(REQ_INSERT, VALUE_MIN);
    send_request(REQ_INSERT, VALUE_MAX);
    send_request(REQ_READ, 32'h5555_AAAA);
  endtask

  // Inserts right behind reads, so each waits out a busy stream.
  task automatic test_back_to_back();
    send_request(REQ_INSERT, 32'sd5);
    send_request(REQ_READ, 32'h0);
    send_request(REQ_INSERT, -32'sd5);
    send_request(REQ_READ, 32'hAAAA_5555);
  endtask

  task automatic test_full_table();
    while (shadow_values.size() < TABLE_DEPTH) send_request(REQ_INSERT, pick_insert_value());
    send_request(REQ_INSERT, VALUE_MIN);
    send_request(REQ_INSERT, VALUE_MAX);
    send_request(REQ_READ, 32'h0);
  endtask

  task automatic test_random_mix(input int unsigned idle_pct, input int unsigned n_items,
                                 input int unsigned insert_pct);
    sender_idle_pct = idle_pct;
    repeat (n_items) begin
      if ($urandom_range(99) < insert_pct) send_request(REQ_INSERT, pick_insert_value());
      else send_request(REQ_READ, word_t'($urandom));
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    start_i         = 1'b0;
    req_type_i      = REQ_INSERT;
    value_i         = '0;
    sender_idle_pct = 0;
    cycle_count     = 0;
    mismatch_count  = 0;
    n_requests      = 0;
    n_inserted      = 0;
    n_dropped       = 0;
    n_reads         = 0;
    n_checked       = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_read();
    test_extreme_values();
    test_back_to_back();
    wait_until_drained();

    test_random_mix(34, 140, 12);
    test_full_table();
    // Let the sender sit still until the block has answered everything.
    wait_until_drained();
    test_random_mix(85, 130, 30);
    test_random_mix(0, 130, 30);

    wait_until_drained();
    repeat (2 * TABLE_DEPTH + 8) @(posedge clk_i);

    $display("Covered %0d requests: %0d stored, %0d dropped on a full table, %0d reads;",
             n_requests, n_inserted, n_dropped, n_reads);
    $display("%0d results compared, %0d mismatches.", n_checked, mismatch_count);
    if (pending_results.size() != 0)
      $display("%0d expected results never arrived", pending_results.size());
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
